>>> hw/rtl/gwlp_pkg.sv
// Shared types, constants and helper functions for the G-code word line parser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gwlp_pkg;

    // Line limits
    localparam logic [4:0] MAX_WORDS       = 5'd16;
    localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;
    localparam logic [46:0] MANT_MAX       = {47{1'b1}};

    // Queue sizes
    localparam int IQ_DEPTH = 4;
    localparam int IQ_AW    = $clog2(IQ_DEPTH);
    localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UL    = 8'h4C;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;

    // Result status codes
    typedef enum logic [2:0] {
        ST_WORD    = 3'd0,
        ST_OK      = 3'd1,
        ST_BADCHAR = 3'd2,
        ST_BADNUM  = 3'd3,
        ST_CRC     = 3'd4
    } status_t;

    // Classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_digit;
        logic [3:0] digit;
        logic       hex_ok;
        logic [3:0] hex;
        logic       is_space;
        logic       is_upper;
        logic       is_star;
        logic       is_minus;
        logic       is_dot;
        logic       is_term;
        logic       is_frac_letter;
    } cls_t;

    // One result item
    typedef struct packed {
        status_t            status;
        logic [7:0]         letter;
        logic               is_frac;
        logic signed [31:0] int_value;
        logic signed [47:0] mantissa;
        logic [3:0]         frac_digits;
        logic [4:0]         word_count;
        logic               last;
    } res_t;

    // Up to two results caused by one byte
    typedef struct packed {
        logic [1:0] count;
        res_t       r0;
        res_t       r1;
    } res_pair_t;

    // Finished word result
    function automatic res_t mk_word(input logic [7:0] ltr, input logic frac,
                                     input logic neg, input logic [31:0] iacc,
                                     input logic [46:0] macc, input logic [3:0] fc);
        res_t        r;
        logic [47:0] m;
        r = '0;
        m = {1'b0, macc};
        r.status = ST_WORD;
        r.letter = ltr;
        if (frac)
        begin
            r.is_frac     = 1'b1;
            r.mantissa    = neg ? (48'd0 - m) : m;
            r.frac_digits = fc;
        end
        else
        begin
            r.int_value = neg ? (32'd0 - iacc) : iacc;
        end
        return r;
    endfunction

    function automatic res_t mk_ok(input logic [4:0] wc);
        res_t r;
        r = '0;
        r.status     = ST_OK;
        r.word_count = wc;
        return r;
    endfunction

    function automatic res_t mk_fail(input status_t s);
        res_t r;
        r = '0;
        r.status = s;
        return r;
    endfunction

    // Append one decimal digit to the mantissa magnitude, saturating
    function automatic logic [46:0] mant_step(input logic [46:0] acc, input logic [3:0] d);
        logic [50:0] w;
        w = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {47'd0, d};
        return (w > {4'd0, MANT_MAX}) ? MANT_MAX : w[46:0];
    endfunction

    // Append one decimal digit to the integer, wrapping
    function automatic logic [31:0] int_step(input logic [31:0] acc, input logic [3:0] d);
        return {acc[28:0], 3'b000} + {acc[30:0], 1'b0} + {28'd0, d};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/gwlp_classify.sv
// Front-end byte classifier: tags each line byte with its character class.
// Depends on gwlp_pkg.
`default_nettype none

module gwlp_classify
    import gwlp_pkg::*;
(
    input  wire logic [7:0] line_byte,
    input  wire logic       buffer_end,
    output cls_t            cls
);

    logic is_lhex;
    logic is_uhex;

    // Decode character classes
    always_comb
    begin
        cls          = '0;
        cls.data     = line_byte;
        cls.last     = buffer_end;
        cls.is_digit = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
        cls.digit    = line_byte[3:0];
        is_lhex      = (line_byte >= CH_LA) && (line_byte <= CH_LF);
        is_uhex      = (line_byte >= CH_UA) && (line_byte <= CH_UF);
        cls.hex_ok   = cls.is_digit || is_lhex || is_uhex;
        // letters a-f / A-F have low nibble 1..6, value is that plus nine
        cls.hex      = cls.is_digit ? line_byte[3:0] : (line_byte[3:0] + 4'd9);
        cls.is_space = (line_byte == CH_SPACE);
        cls.is_upper = (line_byte >= CH_UA) && (line_byte <= CH_UZ);
        cls.is_star  = (line_byte == CH_STAR);
        cls.is_minus = (line_byte == CH_MINUS);
        cls.is_dot   = (line_byte == CH_DOT);
        cls.is_term  = (line_byte == CH_NUL) || (line_byte == CH_SEMI) || (line_byte == CH_NL);
        cls.is_frac_letter = (line_byte == CH_UA) || (line_byte == CH_UB) ||
                             (line_byte == CH_UP) || (line_byte == CH_UL) ||
                             (line_byte == CH_UF) || (line_byte == CH_UT);
    end

endmodule

`default_nettype wire

>>> hw/rtl/gwlp_byte_queue.sv
// Short queue of classified bytes between the front end and the parser core.
// Depends on gwlp_pkg.
`default_nettype none

module gwlp_byte_queue
    import gwlp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cls_t wr_data,
    output logic      full,
    output logic      rd_valid,
    input  wire logic rd_en,
    output cls_t      rd_data
);

    cls_t             mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IQ_CW-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    function automatic logic [IQ_AW-1:0] ptr_inc(input logic [IQ_AW-1:0] p);
        return (p == IQ_AW'(IQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == IQ_CW'(IQ_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming item
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gwlp_exec.sv
// Parser core: runs the word/number/checksum state machine on one classified
// byte per cycle while go is high and produces up to two results. Depends on gwlp_pkg.
`default_nettype none

module gwlp_exec
    import gwlp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic go,
    input  wire cls_t c,
    output res_pair_t res
);

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_LETTER = 7'b0000010,
        PH_INT    = 7'b0000100,
        PH_WHOLE  = 7'b0001000,
        PH_FRAC   = 7'b0010000,
        PH_HEX    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    phase_t      ph_reg, ph_next;
    logic [7:0]  letter_reg, letter_next;
    logic        frac_reg, frac_next;
    logic        neg_reg, neg_next;
    logic        dseen_reg, dseen_next;
    logic [31:0] iacc_reg, iacc_next;
    logic [46:0] macc_reg, macc_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic [31:0] hacc_reg, hacc_next;
    logic [31:0] sum_reg, sum_next;
    logic [4:0]  wcnt_reg, wcnt_next;

    res_t        r0;
    res_t        r1;
    logic [1:0]  cnt;
    logic        do_idle;
    logic        do_fin;

    // Append a result in order
    function automatic void emit(inout res_t a, inout res_t b, inout logic [1:0] n,
                                 input res_t x);
        if (n == 2'd0)
        begin
            a = x;
        end
        else
        begin
            b = x;
        end
        n = n + 2'd1;
    endfunction

    always_comb
    begin
        ph_next     = ph_reg;
        letter_next = letter_reg;
        frac_next   = frac_reg;
        neg_next    = neg_reg;
        dseen_next  = dseen_reg;
        iacc_next   = iacc_reg;
        macc_next   = macc_reg;
        fcnt_next   = fcnt_reg;
        hacc_next   = hacc_reg;
        sum_next    = sum_reg;
        wcnt_next   = wcnt_reg;
        r0          = '0;
        r1          = '0;
        cnt         = 2'd0;
        do_idle     = 1'b0;
        do_fin      = 1'b0;

        if (go)
        begin
            if (ph_reg == PH_DONE)
            begin
                // drop bytes until the buffer end; it restarts the line below
            end
            else
            begin
                // Accumulate the checksum
                if (ph_reg != PH_HEX && !c.is_star)
                begin
                    sum_next = sum_reg + {24'd0, c.data};
                end

                // Advance the number parser
                case (ph_reg)
                    PH_IDLE:
                    begin
                        do_idle = 1'b1;
                    end
                    PH_LETTER:
                    begin
                        if (c.is_digit)
                        begin
                            dseen_next = 1'b1;
                            if (frac_reg)
                            begin
                                macc_next = mant_step(macc_reg, c.digit);
                                ph_next   = PH_WHOLE;
                            end
                            else
                            begin
                                iacc_next = {28'd0, c.digit};
                                ph_next   = PH_INT;
                            end
                        end
                        else if (c.is_minus)
                        begin
                            neg_next = 1'b1;
                            ph_next  = frac_reg ? PH_WHOLE : PH_INT;
                        end
                        else if (c.is_dot && frac_reg)
                        begin
                            ph_next = PH_FRAC;
                        end
                        else
                        begin
                            emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                            ph_next = PH_DONE;
                        end
                    end
                    PH_INT:
                    begin
                        if (c.is_digit)
                        begin
                            iacc_next  = int_step(iacc_reg, c.digit);
                            dseen_next = 1'b1;
                        end
                        else
                        begin
                            do_fin = 1'b1;
                        end
                    end
                    PH_WHOLE:
                    begin
                        if (c.is_digit)
                        begin
                            macc_next  = mant_step(macc_reg, c.digit);
                            dseen_next = 1'b1;
                        end
                        else if (c.is_dot)
                        begin
                            ph_next = PH_FRAC;
                        end
                        else
                        begin
                            do_fin = 1'b1;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (c.is_digit)
                        begin
                            if (fcnt_reg < MAX_FRAC_DIGITS)
                            begin
                                macc_next = mant_step(macc_reg, c.digit);
                                fcnt_next = fcnt_reg + 4'd1;
                            end
                            dseen_next = 1'b1;
                        end
                        else
                        begin
                            do_fin = 1'b1;
                        end
                    end
                    PH_HEX:
                    begin
                        if (c.hex_ok)
                        begin
                            hacc_next  = {hacc_reg[27:0], c.hex};
                            dseen_next = 1'b1;
                        end
                        else if (!dseen_reg)
                        begin
                            emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                            ph_next = PH_DONE;
                        end
                        else if (hacc_reg != sum_reg)
                        begin
                            emit(r0, r1, cnt, mk_fail(ST_CRC));
                            ph_next = PH_DONE;
                        end
                        else
                        begin
                            emit(r0, r1, cnt, mk_ok(wcnt_reg));
                            ph_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                // Close the word ended by this byte
                if (do_fin)
                begin
                    if (!dseen_reg)
                    begin
                        emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                        ph_next = PH_DONE;
                    end
                    else
                    begin
                        emit(r0, r1, cnt, mk_word(letter_reg, frac_reg, neg_reg,
                                                  iacc_reg, macc_reg, fcnt_reg));
                        wcnt_next = wcnt_reg + 5'd1;
                        ph_next   = PH_IDLE;
                        if (wcnt_next >= MAX_WORDS)
                        begin
                            emit(r0, r1, cnt, mk_ok(wcnt_next));
                            ph_next = PH_DONE;
                        end
                        else
                        begin
                            do_idle = 1'b1;
                        end
                    end
                end

                // Handle the byte where a word may start
                if (do_idle)
                begin
                    if (c.is_space)
                    begin
                        // skip
                    end
                    else if (c.is_term)
                    begin
                        emit(r0, r1, cnt, mk_ok(wcnt_next));
                        ph_next = PH_DONE;
                    end
                    else if (c.is_upper)
                    begin
                        letter_next = c.data;
                        frac_next   = c.is_frac_letter;
                        neg_next    = 1'b0;
                        dseen_next  = 1'b0;
                        iacc_next   = '0;
                        macc_next   = '0;
                        fcnt_next   = '0;
                        ph_next     = PH_LETTER;
                    end
                    else if (c.is_star)
                    begin
                        hacc_next  = '0;
                        dseen_next = 1'b0;
                        ph_next    = PH_HEX;
                    end
                    else
                    begin
                        emit(r0, r1, cnt, mk_fail(ST_BADCHAR));
                        ph_next = PH_DONE;
                    end
                end

                // Close the line at the buffer end
                if (c.last)
                begin
                    case (ph_next)
                        PH_IDLE:
                        begin
                            emit(r0, r1, cnt, mk_ok(wcnt_next));
                        end
                        PH_LETTER:
                        begin
                            emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                        end
                        PH_INT, PH_WHOLE, PH_FRAC:
                        begin
                            if (!dseen_next)
                            begin
                                emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                            end
                            else
                            begin
                                emit(r0, r1, cnt, mk_word(letter_next, frac_next, neg_next,
                                                          iacc_next, macc_next, fcnt_next));
                                emit(r0, r1, cnt, mk_ok(wcnt_next + 5'd1));
                            end
                        end
                        PH_HEX:
                        begin
                            if (!dseen_next)
                            begin
                                emit(r0, r1, cnt, mk_fail(ST_BADNUM));
                            end
                            else if (hacc_next != sum_next)
                            begin
                                emit(r0, r1, cnt, mk_fail(ST_CRC));
                            end
                            else
                            begin
                                emit(r0, r1, cnt, mk_ok(wcnt_next));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Restart the line after every buffer end
            if (c.last)
            begin
                ph_next     = PH_IDLE;
                letter_next = '0;
                frac_next   = 1'b0;
                neg_next    = 1'b0;
                dseen_next  = 1'b0;
                iacc_next   = '0;
                macc_next   = '0;
                fcnt_next   = '0;
                hacc_next   = '0;
                sum_next    = '0;
                wcnt_next   = '0;
            end
        end

        // Mark the last result of this byte
        r0.last   = (cnt == 2'd1);
        r1.last   = (cnt == 2'd2);
        res.count = cnt;
        res.r0    = r0;
        res.r1    = r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg     <= PH_IDLE;
            letter_reg <= '0;
            frac_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            dseen_reg  <= 1'b0;
            iacc_reg   <= '0;
            macc_reg   <= '0;
            fcnt_reg   <= '0;
            hacc_reg   <= '0;
            sum_reg    <= '0;
            wcnt_reg   <= '0;
        end
        else
        begin
            ph_reg     <= ph_next;
            letter_reg <= letter_next;
            frac_reg   <= frac_next;
            neg_reg    <= neg_next;
            dseen_reg  <= dseen_next;
            iacc_reg   <= iacc_next;
            macc_reg   <= macc_next;
            fcnt_reg   <= fcnt_next;
            hacc_reg   <= hacc_next;
            sum_reg    <= sum_next;
            wcnt_reg   <= wcnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gwlp_result_fifo.sv
// Result queue: takes up to two results per cycle from the parser core and
// hands out one per pop. Depends on gwlp_pkg.
`default_nettype none

module gwlp_result_fifo
    import gwlp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire res_pair_t wr_pair,
    output logic           room2,
    output logic           empty,
    input  wire logic      pop,
    output res_t           rd_data
);

    res_t             mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CW-1:0] count_reg, count_next;
    logic [OQ_AW-1:0] wr_ptr_1;
    logic             do_rd;

    function automatic logic [OQ_AW-1:0] ptr_inc(input logic [OQ_AW-1:0] p);
        return (p == OQ_AW'(OQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty    = (count_reg == '0);
    assign room2    = (count_reg <= OQ_CW'(OQ_DEPTH - 2));
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_rd    = pop && !empty;
    assign wr_ptr_1 = ptr_inc(wr_ptr_reg);

    // Advance pointers and occupancy
    always_comb
    begin
        case (wr_pair.count)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = do_rd ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + OQ_CW'(wr_pair.count) - OQ_CW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the new results in order
    always_ff @(posedge clk)
    begin
        if (wr_pair.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= wr_pair.r0;
        end
        if (wr_pair.count == 2'd2)
        begin
            mem_reg[wr_ptr_1] <= wr_pair.r1;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gcode_word_line_parser.sv
// G-code word line parser, top level.
//
// Input channel: one line byte per item with a buffer_end flag that marks the
// last byte of the supplied buffer. An item is taken at a clock edge with push
// high and full low. Result channel: while empty is low the oldest result sits
// on the result ports; it is taken at an edge with pop high.
//
// Each byte may cause zero, one or two results (a finished word, a line-ok or
// an error); last_of_run marks the final one for that byte.
// A taken byte waits in the byte queue and is parsed once it heads the queue
// while the result queue has room for two results; its results are written
// into the four-entry result queue at that edge. The parser core takes one byte
// per cycle while that queue has room, and results leave one per cycle while
// pop is high. A four-entry byte queue lets the input side keep pushing while
// the result side stalls; full rises once both queues are backed up.
//
// Reset clears both queues and puts the parser at the start of a line.
// Depends on gwlp_pkg, gwlp_classify, gwlp_byte_queue, gwlp_exec and
// gwlp_result_fifo.
`default_nettype none

module gcode_word_line_parser
    import gwlp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         line_byte,
    input  wire logic               buffer_end,
    output logic                    empty,
    input  wire logic               pop,
    output logic [2:0]              status,
    output logic [7:0]              word_letter,
    output logic                    is_fractional,
    output logic signed [31:0]      int_value,
    output logic signed [47:0]      mantissa,
    output logic [3:0]              fraction_digits,
    output logic [4:0]              word_count,
    output logic                    last_of_run
);

    cls_t      in_cls;
    cls_t      q_cls;
    logic      q_valid;
    logic      room2;
    logic      go;
    res_pair_t pair;
    res_t      head;

    // Classify the incoming byte
    gwlp_classify u_classify (
        .line_byte  (line_byte),
        .buffer_end (buffer_end),
        .cls        (in_cls)
    );

    // Hold classified bytes until the core takes them
    gwlp_byte_queue u_byte_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (in_cls),
        .full     (full),
        .rd_valid (q_valid),
        .rd_en    (go),
        .rd_data  (q_cls)
    );

    // Parse one byte when there is room for its results
    assign go = q_valid && room2;

    gwlp_exec u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go),
        .c     (q_cls),
        .res   (pair)
    );

    gwlp_result_fifo u_result_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_pair (pair),
        .room2   (room2),
        .empty   (empty),
        .pop     (pop),
        .rd_data (head)
    );

    // Drive the result ports from the queue head
    assign status          = head.status;
    assign word_letter     = head.letter;
    assign is_fractional   = head.is_frac;
    assign int_value       = head.int_value;
    assign mantissa        = head.mantissa;
    assign fraction_digits = head.frac_digits;
    assign word_count      = head.word_count;
    assign last_of_run     = head.last;

endmodule

`default_nettype wire

>>> dv/tb_gcode_word_line_parser.sv
// Self-checking testbench for gcode_word_line_parser: line bytes in, parsed words out.
// Depends on gwlp_pkg for status codes, character codes and the result layout.
`timescale 1ns / 100ps

module tb_gcode_word_line_parser;
    import gwlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int BYTES_PER_PHASE = 350;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LETTER,
        PH_INT,
        PH_WHOLE,
        PH_FRAC,
        PH_HEX,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               push       = 1'b0;
    logic [7:0]         line_byte  = '0;
    logic               buffer_end = 1'b0;
    logic               pop        = 1'b0;
    wire                full;
    wire                empty;
    wire [2:0]          status;
    wire [7:0]          word_letter;
    wire                is_fractional;
    wire signed [31:0]  int_value;
    wire signed [47:0]  mantissa;
    wire [3:0]          fraction_digits;
    wire [4:0]          word_count;
    wire                last_of_run;

    wire took_byte   = push && !full;
    wire took_result = pop && !empty;

    // Stimulus and result stores
    byte_item_t  byte_q[$];
    logic [7:0]  line_buf[$];
    res_t        parsed_results[$];
    res_t        run_q[$];
    byte_item_t  next_byte;
    res_t        seen_res;
    res_t        want_res;
    int          queued_bytes   = 0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    // Parser state mirror
    phase_t      p_phase   = PH_IDLE;
    logic [7:0]  p_letter  = '0;
    logic        p_neg     = 1'b0;
    logic        p_seen    = 1'b0;
    logic [31:0] p_int     = '0;
    logic [47:0] p_mant    = '0;
    logic [3:0]  p_fcnt    = '0;
    logic [31:0] p_hex     = '0;
    logic [31:0] p_sum     = '0;
    logic [4:0]  p_words   = '0;

    gcode_word_line_parser uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .line_byte       (line_byte),
        .buffer_end      (buffer_end),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .word_letter     (word_letter),
        .is_fractional   (is_fractional),
        .int_value       (int_value),
        .mantissa        (mantissa),
        .fraction_digits (fraction_digits),
        .word_count      (word_count),
        .last_of_run     (last_of_run)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Line parsing, mirrored byte by byte
    // ---------------------------------------------------------------
    function automatic logic is_frac_ltr(input logic [7:0] c);
        return c == CH_UA || c == CH_UB || c == CH_UP || c == CH_UL
            || c == CH_UF || c == CH_UT;
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // Bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (is_dec(b))
            v = b - CH_ZERO;
        else if (b >= CH_LA && b <= CH_LF)
            v = b - CH_LA + 8'd10;
        else if (b >= CH_UA && b <= CH_UF)
            v = b - CH_UA + 8'd10;
        else
            return 5'd0;
        return {1'b1, v[3:0]};
    endfunction

    function automatic void add_res(input status_t st, input logic [7:0] ltr,
                                    input logic frac, input logic [31:0] iv,
                                    input logic [47:0] m, input logic [3:0] fd,
                                    input logic [4:0] wc);
        res_t r;
        r = '0;
        r.status      = st;
        r.letter      = ltr;
        r.is_frac     = frac;
        r.int_value   = iv;
        r.mantissa    = m;
        r.frac_digits = fd;
        r.word_count  = wc;
        // at most two results per byte
        if (run_q.size() < 2)
            run_q.push_back(r);
    endfunction

    function automatic void abort_line(input status_t st);
        add_res(st, 8'd0, 1'b0, 32'd0, 48'd0, 4'd0, 5'd0);
        p_phase = PH_DONE;
    endfunction

    function automatic void close_line();
        add_res(ST_OK, 8'd0, 1'b0, 32'd0, 48'd0, 4'd0, p_words);
        p_phase = PH_DONE;
    endfunction

    function automatic void clear_parse();
        p_phase  = PH_IDLE;
        p_letter = '0;
        p_neg    = 1'b0;
        p_seen   = 1'b0;
        p_int    = '0;
        p_mant   = '0;
        p_fcnt   = '0;
        p_hex    = '0;
        p_sum    = '0;
        p_words  = '0;
    endfunction

    // Saturate the magnitude at the largest 47-bit value
    function automatic void mant_digit(input logic [7:0] b);
        logic [47:0] d;
        d = {40'd0, b - CH_ZERO};
        if (p_mant > ({1'b0, MANT_MAX} - d) / 48'd10)
            p_mant = {1'b0, MANT_MAX};
        else
            p_mant = p_mant * 48'd10 + d;
    endfunction

    // Emit the finished word; 1 when the ending byte still needs handling
    function automatic logic close_word();
        if (!p_seen)
        begin
            abort_line(ST_BADNUM);
            return 1'b0;
        end
        if (is_frac_ltr(p_letter))
            add_res(ST_WORD, p_letter, 1'b1, 32'd0,
                    p_neg ? 48'd0 - p_mant : p_mant, p_fcnt, 5'd0);
        else
            add_res(ST_WORD, p_letter, 1'b0, p_neg ? 32'd0 - p_int : p_int,
                    48'd0, 4'd0, 5'd0);
        p_words = p_words + 5'd1;
        p_phase = PH_IDLE;
        if (p_words >= MAX_WORDS)
        begin
            close_line();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void close_checksum();
        if (!p_seen)
            abort_line(ST_BADNUM);
        else if (p_hex != p_sum)
            abort_line(ST_CRC);
        else
            close_line();
    endfunction

    function automatic void word_start(input logic [7:0] b);
        if (b == CH_SPACE)
            return;
        if (b == CH_NUL || b == CH_SEMI || b == CH_NL)
            close_line();
        else if (b >= CH_UA && b <= CH_UZ)
        begin
            p_letter = b;
            p_neg    = 1'b0;
            p_seen   = 1'b0;
            p_int    = '0;
            p_mant   = '0;
            p_fcnt   = '0;
            p_phase  = PH_LETTER;
        end
        else if (b == CH_STAR)
        begin
            p_hex   = '0;
            p_seen  = 1'b0;
            p_phase = PH_HEX;
        end
        else
            abort_line(ST_BADCHAR);
    endfunction

    function automatic void parse_line_byte(input logic [7:0] b, input logic be);
        logic [4:0] hn;
        run_q.delete();
        // drop bytes until the buffer ends
        if (p_phase == PH_DONE)
        begin
            if (be)
                clear_parse();
            return;
        end
        if (p_phase != PH_HEX && b != CH_STAR)
            p_sum = p_sum + {24'd0, b};
        case (p_phase)
            PH_IDLE:
                word_start(b);
            PH_LETTER:
            begin
                if (is_dec(b))
                begin
                    if (is_frac_ltr(p_letter))
                    begin
                        mant_digit(b);
                        p_phase = PH_WHOLE;
                    end
                    else
                    begin
                        p_int   = {24'd0, b - CH_ZERO};
                        p_phase = PH_INT;
                    end
                    p_seen = 1'b1;
                end
                else if (b == CH_MINUS)
                begin
                    p_neg   = 1'b1;
                    p_phase = is_frac_ltr(p_letter) ? PH_WHOLE : PH_INT;
                end
                else if (b == CH_DOT && is_frac_ltr(p_letter))
                    p_phase = PH_FRAC;
                else
                    abort_line(ST_BADNUM);
            end
            PH_INT:
            begin
                if (is_dec(b))
                begin
                    p_int  = p_int * 32'd10 + {24'd0, b - CH_ZERO};
                    p_seen = 1'b1;
                end
                else if (close_word())
                    word_start(b);
            end
            PH_WHOLE:
            begin
                if (is_dec(b))
                begin
                    mant_digit(b);
                    p_seen = 1'b1;
                end
                else if (b == CH_DOT)
                    p_phase = PH_FRAC;
                else if (close_word())
                    word_start(b);
            end
            PH_FRAC:
            begin
                if (is_dec(b))
                begin
                    // drop digits past the fraction limit
                    if (p_fcnt < MAX_FRAC_DIGITS)
                    begin
                        mant_digit(b);
                        p_fcnt = p_fcnt + 4'd1;
                    end
                    p_seen = 1'b1;
                end
                else if (close_word())
                    word_start(b);
            end
            PH_HEX:
            begin
                hn = hex_nibble(b);
                if (hn[4])
                begin
                    p_hex  = {p_hex[27:0], hn[3:0]};
                    p_seen = 1'b1;
                end
                else
                    close_checksum();
            end
            default:
                ;
        endcase
        // buffer end closes whatever is open
        if (be)
        begin
            case (p_phase)
                PH_IDLE:
                    close_line();
                PH_LETTER:
                    abort_line(ST_BADNUM);
                PH_INT, PH_WHOLE, PH_FRAC:
                    if (close_word())
                        close_line();
                PH_HEX:
                    close_checksum();
                default:
                    ;
            endcase
            clear_parse();
        end
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            parsed_results.push_back(run_q[i]);
    endfunction

    // ---------------------------------------------------------------
    // Line building
    // ---------------------------------------------------------------
    task automatic put_byte(input logic [7:0] d, input logic e);
        byte_item_t it;
        it.data = d;
        it.last = e;
        byte_q.push_back(it);
        queued_bytes++;
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // Send the line with the buffer end on its final byte
    task automatic flush_line();
        int i;
        if (line_buf.size() == 0)
            line_buf.push_back(CH_SPACE);
        for (i = 0; i < line_buf.size(); i++)
            put_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic add_digits(input int n);
        int i;
        for (i = 0; i < n; i++)
            line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic add_checksum(input logic good);
        logic [31:0] sum;
        string       hx;
        sum = '0;
        foreach (line_buf[i])
            sum = sum + {24'd0, line_buf[i]};
        if (!good)
            sum = sum + $urandom_range(1, 255);
        hx = ($urandom_range(3) == 0) ? $sformatf("%08h", sum) : $sformatf("%0h", sum);
        if ($urandom_range(1) == 0)
            hx = hx.toupper();
        line_buf.push_back(CH_STAR);
        add_text(hx);
    endtask

    function automatic int digit_run();
        return ($urandom_range(7) == 0) ? $urandom_range(8, 18) : $urandom_range(1, 4);
    endfunction

    task automatic add_word();
        logic [7:0] ltr;
        int         whole_n;
        int         frac_n;
        logic       has_dot;
        ltr = CH_UA + 8'($urandom_range(25));
        line_buf.push_back(ltr);
        if ($urandom_range(3) == 0)
            line_buf.push_back(CH_MINUS);
        if (is_frac_ltr(ltr))
        begin
            whole_n = ($urandom_range(3) == 0) ? 0 : digit_run();
            has_dot = 1'($urandom_range(1));
            frac_n  = ($urandom_range(5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
            if (whole_n == 0 && (!has_dot || frac_n == 0))
                whole_n = 1;
            add_digits(whole_n);
            if (has_dot)
            begin
                line_buf.push_back(CH_DOT);
                add_digits(frac_n);
            end
        end
        else
            add_digits(digit_run());
    endtask

    // Mostly well-formed lines; some noise and some damaged lines
    task automatic gen_line();
        int kind;
        int nwords;
        int i;
        int idx;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            nwords = $urandom_range(1, 12);
            for (i = 0; i < nwords; i++)
                put_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
            put_byte(8'($urandom_range(255)), 1'b1);
            return;
        end
        nwords = ($urandom_range(9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
        for (i = 0; i < nwords; i++)
        begin
            if ($urandom_range(2) == 0)
                add_text($urandom_range(1) ? " " : "  ");
            add_word();
        end
        case ($urandom_range(9))
            0, 1: line_buf.push_back(CH_SEMI);
            2, 3: line_buf.push_back(CH_NL);
            4:    line_buf.push_back(CH_NUL);
            5:    ;
            6, 7, 8:
            begin
                add_checksum($urandom_range(3) != 0);
                case ($urandom_range(3))
                    0:       line_buf.push_back(CH_SEMI);
                    1:       line_buf.push_back(CH_NL);
                    2:       line_buf.push_back(CH_SPACE);
                    default: ;
                endcase
            end
            default: add_text("  ");
        endcase
        // damage one byte
        if (kind < 30 && line_buf.size() > 0)
        begin
            idx = $urandom_range(line_buf.size() - 1);
            case ($urandom_range(6))
                0:       line_buf[idx] = CH_MINUS;
                1:       line_buf[idx] = CH_DOT;
                2:       line_buf[idx] = CH_STAR;
                3:       line_buf[idx] = CH_SPACE;
                4:       line_buf[idx] = CH_UA + 8'($urandom_range(25));
                5:       line_buf[idx] = CH_NL;
                default: line_buf[idx] = 8'($urandom_range(255));
            endcase
        end
        // trailing bytes after the line end; dropped only if the line closed first
        if ($urandom_range(2) == 0)
            for (i = $urandom_range(1, 5); i > 0; i--)
                line_buf.push_back(8'($urandom_range(32, 126)));
        flush_line();
    endtask

    task automatic run_directed();
        int i;
        add_text("G1 X-25 Y3");
        line_buf.push_back(CH_NL);
        flush_line();
        add_text("F12.5;");
        flush_line();
        // buffer end right after digits
        add_text("A.5");
        flush_line();
        // fraction digits past the limit
        add_text("T-0.000000000012 B7 F5.");
        flush_line();
        // mantissa saturation both signs
        add_text("P999999999999999999 B-99999999999999.9");
        flush_line();
        // integer extremes and wrap
        add_text("X4294967297 Y-2147483648 Z2147483647 M2147483648");
        flush_line();
        add_text("G1X2M3;junk");
        flush_line();
        add_text("G1 #");
        flush_line();
        add_text("g1");
        flush_line();
        add_text("G");
        flush_line();
        add_text("X-");
        flush_line();
        add_text("F.");
        flush_line();
        add_text("F-.;");
        flush_line();
        add_text("GX");
        flush_line();
        add_text("G.5");
        flush_line();
        add_text("G 1");
        flush_line();
        add_text("F.5.");
        flush_line();
        add_text("*");
        flush_line();
        add_text("*;");
        flush_line();
        add_text("   ");
        flush_line();
        add_text("G1 ");
        flush_line();
        add_text("G0");
        line_buf.push_back(CH_NUL);
        add_text("X1");
        flush_line();
        // checksum match ended by a byte, then by the buffer end, then a mismatch
        add_text("G1 X2 F3.5");
        add_checksum(1'b1);
        line_buf.push_back(CH_SEMI);
        flush_line();
        add_text("T12 M6");
        add_checksum(1'b1);
        flush_line();
        add_text("G1");
        add_checksum(1'b0);
        flush_line();
        // word limit, ended by a space and by the buffer end
        for (i = 1; i <= 17; i++)
            add_text($sformatf("X%0d ", i));
        flush_line();
        for (i = 1; i <= 16; i++)
            add_text($sformatf("G%0d", i));
        flush_line();
    endtask

    // ---------------------------------------------------------------
    // Driver: feed line bytes, model each one as it is taken
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (took_byte)
                parse_line_byte(line_byte, buffer_end);
            if (!push || !full)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_byte = byte_q.pop_front();
                    push       <= 1'b1;
                    line_byte  <= next_byte.data;
                    buffer_end <= next_byte.last;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each taken result with the oldest parsed one
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (took_result)
            begin
                seen_res.status      = status_t'(status);
                seen_res.letter      = word_letter;
                seen_res.is_frac     = is_fractional;
                seen_res.int_value   = int_value;
                seen_res.mantissa    = mantissa;
                seen_res.frac_digits = fraction_digits;
                seen_res.word_count  = word_count;
                seen_res.last        = last_of_run;
                if (parsed_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: status %0d letter %h wc %0d",
                                 status, word_letter, word_count);
                end
                else
                begin
                    want_res = parsed_results.pop_front();
                    if (seen_res.status !== want_res.status
                        || seen_res.letter !== want_res.letter
                        || seen_res.is_frac !== want_res.is_frac
                        || seen_res.int_value !== want_res.int_value
                        || seen_res.mantissa !== want_res.mantissa
                        || seen_res.frac_digits !== want_res.frac_digits
                        || seen_res.word_count !== want_res.word_count
                        || seen_res.last !== want_res.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp st %0d ltr %h fr %0b int %0d mant %0d ",
                                      "fd %0d wc %0d last %0b / got st %0d ltr %h fr %0b ",
                                      "int %0d mant %0d fd %0d wc %0d last %0b"},
                                     want_res.status, want_res.letter, want_res.is_frac,
                                     want_res.int_value, want_res.mantissa,
                                     want_res.frac_digits, want_res.word_count,
                                     want_res.last, seen_res.status, seen_res.letter,
                                     seen_res.is_frac, seen_res.int_value,
                                     seen_res.mantissa, seen_res.frac_digits,
                                     seen_res.word_count, seen_res.last);
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (took_byte || took_result)
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb_gcode_word_line_parser NOT OK");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, then three idling phases
    // ---------------------------------------------------------------
    initial
    begin
        int phase;
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 64;
                    run_directed();
                end
                1:
                begin
                    send_idle_pct = 64;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (queued_bytes < BYTES_PER_PHASE * (phase + 1))
                gen_line();
            // drain before changing the idling mix
            while (byte_q.size() > 0 || push || parsed_results.size() > 0)
                @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && parsed_results.size() == 0)
            $display("tb_gcode_word_line_parser OK");
        else
            $display("tb_gcode_word_line_parser NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/gwlp_pkg.sv
hw/rtl/gwlp_classify.sv
hw/rtl/gwlp_byte_queue.sv
hw/rtl/gwlp_exec.sv
hw/rtl/gwlp_result_fifo.sv
hw/rtl/gcode_word_line_parser.sv
dv/tb_gcode_word_line_parser.sv
